// ===== hdl/char_lcd_nibble_write_sequencer_assert.svh =====
// Assertion macros used by the character LCD sequencer back end.
// Depends on nothing; included by chrlcd_back, the module that carries assertions.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHRLCD_ASSERT_IMPLIES(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("chrlcd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHRLCD_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("chrlcd assertion failed");

`endif

// ===== hdl/chrlcd_pkg.sv =====
// Package for the character LCD 4-bit write sequencer: payload types, job
// format, codes and the initialization job table. Depends on nothing.
package chrlcd_pkg;

    localparam int HOLD_W         = 20;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int INIT_STEP_W    = 4;
    localparam int CFG_ADDR_W     = 5;
    localparam int CFG_DATA_W     = 32;

    // Operation codes.
    localparam logic [2:0] OP_INIT      = 3'd0;
    localparam logic [2:0] OP_WRITE_CMD = 3'd1;
    localparam logic [2:0] OP_WRITE_DAT = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_POSITION  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_RS_SETTLE    = 3'd0;
    localparam logic [2:0] REG_NIBBLE_SETUP = 3'd1;
    localparam logic [2:0] REG_STROBE_WIDTH = 3'd2;
    localparam logic [2:0] REG_POWER_WAIT   = 3'd3;
    localparam logic [2:0] REG_MID_WAIT     = 3'd4;
    localparam logic [2:0] REG_FINAL_WAIT   = 3'd5;

    // Display commands.
    localparam logic [7:0] CMD_WAKE_A     = 8'h33;
    localparam logic [7:0] CMD_WAKE_B     = 8'h32;
    localparam logic [7:0] CMD_FUNCTION   = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0E;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] LINE1_BASE     = 8'h80;
    localparam logic [7:0] LINE2_BASE     = 8'hC0;

    localparam logic [1:0] ROW_LINE1 = 2'd1;
    localparam logic [1:0] ROW_LINE2 = 2'd2;

    localparam logic [INIT_STEP_W-1:0] INIT_LAST_STEP = 4'd8;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] byte_value;
        logic [1:0] row;
        logic [5:0] column;
    } in_item_t;

    typedef struct packed {
        logic              reg_select;
        logic              enable;
        logic [3:0]        nibble;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [9:0]  rs_settle_us;
        logic [15:0] nibble_setup_us;
        logic [9:0]  strobe_width_us;
        logic [19:0] power_up_wait_us;
        logic [19:0] mid_init_wait_us;
        logic [19:0] final_init_wait_us;
    } cfg_t;

    typedef enum logic [1:0] {
        WAIT_POWER,
        WAIT_MID,
        WAIT_FINAL
    } wait_sel_t;

    // One unit of back-end work: a whole byte or a single wait phase.
    typedef struct packed {
        logic       is_wait;
        logic       rs;
        logic [7:0] byte_value;
        wait_sel_t  wait_sel;
        logic       last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic {
        FR_IDLE,
        FR_INIT
    } front_state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_PLACE,
        PH_EXTRA,
        PH_EN_HI,
        PH_EN_LO,
        PH_AFTER,
        PH_WAIT
    } phase_t;

    function automatic job_t cmd_job(input logic [7:0] value);
        job_t j;
        j.is_wait    = 1'b0;
        j.rs         = 1'b0;
        j.byte_value = value;
        j.wait_sel   = WAIT_POWER;
        j.last       = 1'b0;
        return j;
    endfunction

    function automatic job_t wait_job(input wait_sel_t sel);
        job_t j;
        j.is_wait    = 1'b1;
        j.rs         = 1'b0;
        j.byte_value = 8'h00;
        j.wait_sel   = sel;
        j.last       = 1'b0;
        return j;
    endfunction

    // Job list of the initialization request, one entry per step.
    function automatic job_t init_job(input logic [INIT_STEP_W-1:0] step);
        job_t j;
        unique case (step)
            4'd0:    j = wait_job(WAIT_POWER);
            4'd1:    j = cmd_job(CMD_WAKE_A);
            4'd2:    j = cmd_job(CMD_WAKE_B);
            4'd3:    j = wait_job(WAIT_MID);
            4'd4:    j = cmd_job(CMD_FUNCTION);
            4'd5:    j = cmd_job(CMD_DISPLAY_ON);
            4'd6:    j = cmd_job(CMD_ENTRY_MODE);
            4'd7:    j = cmd_job(CMD_CLEAR);
            default: begin
                j      = wait_job(WAIT_FINAL);
                j.last = 1'b1;
            end
        endcase
        return j;
    endfunction

    // Data pin levels shown during a wait phase.
    function automatic logic [3:0] wait_nibble(input wait_sel_t sel);
        logic [3:0] n;
        unique case (sel)
            WAIT_MID:   n = 4'h2;
            WAIT_FINAL: n = 4'h1;
            default:    n = 4'h0;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/chrlcd_front.sv =====
// Front end of the LCD sequencer: accepts requests and breaks them into jobs.
// Depends on chrlcd_pkg.
module chrlcd_front
    import chrlcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    input  q_status_t q_status,
    output logic      push,
    output job_t      push_job
);

    front_state_t               state_reg, state_next;
    logic [INIT_STEP_W-1:0]     step_reg, step_next;
    job_t                       req_job;
    logic                       req_has_job;
    logic                       accept;

    // Classify a single-byte request into one job, or none for an unused row or code.
    always_comb begin
        req_job      = cmd_job(s_item.byte_value);
        req_job.last = 1'b1;
        req_has_job  = 1'b1;
        priority case (s_item.operation)
            OP_WRITE_CMD: req_job.rs = 1'b0;
            OP_WRITE_DAT: req_job.rs = 1'b1;
            OP_CLEAR:     req_job.byte_value = CMD_CLEAR;
            OP_POSITION: begin
                if (s_item.row == ROW_LINE1) begin
                    req_job.byte_value = 8'(LINE1_BASE + {2'b00, s_item.column});
                end else if (s_item.row == ROW_LINE2) begin
                    req_job.byte_value = 8'(LINE2_BASE + {2'b00, s_item.column});
                end else begin
                    req_has_job = 1'b0;
                end
            end
            default: req_has_job = 1'b0;
        endcase
    end

    assign s_ready = (state_reg == FR_IDLE) && !q_status.full;
    assign accept  = s_valid && s_ready;

    // Next state and queue push.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        push       = 1'b0;
        push_job   = req_job;
        unique case (state_reg)
            FR_IDLE: begin
                if (accept) begin
                    if (s_item.operation == OP_INIT) begin
                        state_next = FR_INIT;
                        step_next  = '0;
                    end else begin
                        push = req_has_job;
                    end
                end
            end
            FR_INIT: begin
                push_job = init_job(step_reg);
                if (!q_status.full) begin
                    push = 1'b1;
                    if (step_reg == INIT_LAST_STEP) begin
                        state_next = FR_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== hdl/chrlcd_queue.sv =====
// Short job queue between the front and back ends of the LCD sequencer.
// Depends on chrlcd_pkg.
module chrlcd_queue
    import chrlcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      pop_job,
    output q_status_t q_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    job_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign q_status = '{full: (count_reg == CNT_W'(DEPTH)), empty: (count_reg == '0)};
    assign do_push  = push && !q_status.full;
    assign do_pop   = pop && !q_status.empty;
    assign pop_job  = slot_reg[rd_ptr_reg];

    // Storage; slots carry payload only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers wrap at the last slot, so any depth of two or more works; fill count alongside.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/chrlcd_back.sv =====
// Back end of the LCD sequencer: turns queued jobs into pin phases and holds
// the result in an output register. Depends on chrlcd_pkg and the assert macros.
`include "char_lcd_nibble_write_sequencer_assert.svh"

module chrlcd_back
    import chrlcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  q_status_t q_status,
    input  job_t      q_job,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    phase_t     state_reg, state_next;
    logic       half_reg, half_next;
    job_t       job_reg, job_next;
    out_item_t  m_item_reg, m_item_next;
    logic       m_valid_reg, m_valid_next;
    logic       advance;
    out_item_t  phase_item;
    logic [3:0] byte_nibble;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A phase moves into the output register whenever that register frees up.
    assign advance = (state_reg != PH_IDLE) && (!m_valid_reg || m_ready);

    assign byte_nibble = half_reg ? job_reg.byte_value[3:0] : job_reg.byte_value[7:4];

    // Pin levels and hold time of the current phase.
    always_comb begin
        phase_item.reg_select = job_reg.rs;
        phase_item.enable     = (state_reg == PH_EN_HI);
        phase_item.nibble     = byte_nibble;
        phase_item.last       = 1'b0;
        phase_item.hold_us    = HOLD_W'(cfg.nibble_setup_us);
        unique case (state_reg)
            PH_SETTLE: begin
                phase_item.nibble  = 4'h0;
                phase_item.hold_us = HOLD_W'(cfg.rs_settle_us);
            end
            PH_EN_HI, PH_EN_LO: begin
                phase_item.hold_us = HOLD_W'(cfg.strobe_width_us);
            end
            PH_AFTER: begin
                phase_item.last = job_reg.last && half_reg;
            end
            PH_WAIT: begin
                phase_item.nibble = wait_nibble(job_reg.wait_sel);
                phase_item.last   = job_reg.last;
                priority case (job_reg.wait_sel)
                    WAIT_MID:   phase_item.hold_us = cfg.mid_init_wait_us;
                    WAIT_FINAL: phase_item.hold_us = cfg.final_init_wait_us;
                    default:    phase_item.hold_us = cfg.power_up_wait_us;
                endcase
            end
            default: begin
            end
        endcase
    end

    // Phase sequencer: next state, job load and output register update.
    always_comb begin
        state_next   = state_reg;
        half_next    = half_reg;
        job_next     = job_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pop          = 1'b0;
        if (state_reg == PH_IDLE) begin
            if (!q_status.empty) begin
                pop        = 1'b1;
                job_next   = q_job;
                half_next  = 1'b0;
                state_next = q_job.is_wait ? PH_WAIT : PH_SETTLE;
            end
        end else if (advance) begin
            m_item_next  = phase_item;
            m_valid_next = 1'b1;
            unique case (state_reg)
                PH_SETTLE: state_next = PH_PLACE;
                PH_PLACE:  state_next = job_reg.rs ? PH_EXTRA : PH_EN_HI;
                PH_EXTRA:  state_next = PH_EN_HI;
                PH_EN_HI:  state_next = PH_EN_LO;
                PH_EN_LO:  state_next = PH_AFTER;
                PH_AFTER: begin
                    if (half_reg) begin
                        state_next = PH_IDLE;
                    end else begin
                        half_next  = 1'b1;
                        state_next = PH_PLACE;
                    end
                end
                default: state_next = PH_IDLE;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PH_IDLE;
            half_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            half_reg    <= half_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_item_reg <= m_item_next;
    end

    `CHRLCD_ASSERT_IMPLIES(a_pop_when_idle, aclk, aresetn, pop, state_reg == PH_IDLE)
    `CHRLCD_ASSERT_IMPLIES(a_extra_only_data, aclk, aresetn, state_reg == PH_EXTRA, job_reg.rs)
    `CHRLCD_ASSERT_IMPLIES(a_wait_from_wait_job, aclk, aresetn, state_reg == PH_WAIT, job_reg.is_wait)
    `CHRLCD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg)
    `CHRLCD_ASSERT_NEXT(a_hold_item, aclk, aresetn, m_valid_reg && !m_ready, $stable(m_item_reg))

endmodule

// ===== hdl/char_lcd_nibble_write_sequencer.sv =====
// Character LCD 4-bit write sequencer, top level with the register port.
// Depends on chrlcd_pkg, chrlcd_front, chrlcd_queue and chrlcd_back.
//
// Usage: requests (init, write command, write data, clear, set position)
// enter on the s_ valid/ready channel, one beat each. Every request becomes
// a list of pin phases on the m_ channel, one beat per phase, with last set
// on the final phase. A command byte gives 9 phases, a data byte 11, init 57;
// a position request for row 0 or 3 and an unused operation give none.
// Throughput: one phase per cycle while m_ready is high, except that each
// byte or wait job is first loaded from the job queue.
// The front end pushes the job of a byte request in the same cycle as it
// accepts it (init is expanded job by job, pausing while the queue is full),
// then the next request may enter while the back end is still emitting.
// With the back end idle, the first phase of a byte request passes the job
// queue, the back end's job and state registers and the output register before
// m_valid rises. The queue depth sets how far the front may run ahead.
// A stall on m_ready holds the current phase in the output register; the
// back end and then the queue fill, and s_ready falls.
// Reset (aresetn low, synchronous) empties the queue, drops any request in
// flight and loads the timing registers with their defaults. The user must write
// registers over the APB port only while the block is idle; the block does not enforce it.
module char_lcd_nibble_write_sequencer
    import chrlcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] reg_index;
    logic       cfg_write;
    q_status_t  q_status;
    logic       push, pop;
    job_t       push_job, q_job;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            priority case (reg_index)
                REG_RS_SETTLE:    cfg_next.rs_settle_us       = pwdata[9:0];
                REG_NIBBLE_SETUP: cfg_next.nibble_setup_us    = pwdata[15:0];
                REG_STROBE_WIDTH: cfg_next.strobe_width_us    = pwdata[9:0];
                REG_POWER_WAIT:   cfg_next.power_up_wait_us   = pwdata[19:0];
                REG_MID_WAIT:     cfg_next.mid_init_wait_us   = pwdata[19:0];
                REG_FINAL_WAIT:   cfg_next.final_init_wait_us = pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rs_settle_us       <= 10'd4;
            cfg_reg.nibble_setup_us    <= 16'd830;
            cfg_reg.strobe_width_us    <= 10'd83;
            cfg_reg.power_up_wait_us   <= 20'd1000000;
            cfg_reg.mid_init_wait_us   <= 20'd30000;
            cfg_reg.final_init_wait_us <= 20'd10000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back.
    always_comb begin
        priority case (reg_index)
            REG_RS_SETTLE:    prdata = CFG_DATA_W'(cfg_reg.rs_settle_us);
            REG_NIBBLE_SETUP: prdata = CFG_DATA_W'(cfg_reg.nibble_setup_us);
            REG_STROBE_WIDTH: prdata = CFG_DATA_W'(cfg_reg.strobe_width_us);
            REG_POWER_WAIT:   prdata = CFG_DATA_W'(cfg_reg.power_up_wait_us);
            REG_MID_WAIT:     prdata = CFG_DATA_W'(cfg_reg.mid_init_wait_us);
            REG_FINAL_WAIT:   prdata = CFG_DATA_W'(cfg_reg.final_init_wait_us);
            default:          prdata = '0;
        endcase
    end

    chrlcd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    chrlcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (q_job),
        .q_status (q_status)
    );

    chrlcd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_job    (q_job),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

// ===== verif/char_lcd_nibble_write_sequencer_tb.sv =====
// Testbench for the character LCD 4-bit write sequencer: directed and random requests,
// checked phase by phase against a local model of the pin sequence.
// Depends on chrlcd_pkg and char_lcd_nibble_write_sequencer.
`timescale 1ns / 100ps

module char_lcd_nibble_write_sequencer_tb;
    import chrlcd_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 40;
    localparam int ITEMS_PER_SET = 45;
    localparam int NUM_SETTINGS  = 5;
    localparam int TIMEOUT_NS    = 4_000_000;

    // Codes the block must ignore.
    localparam logic [2:0] OP_RESERVED_LO  = 3'd5;
    localparam logic [2:0] OP_RESERVED_MID = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI  = 3'd7;
    localparam logic [2:0] REG_UNUSED_LO   = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI   = 3'd7;
    localparam logic [1:0] ROW_NONE_LO     = 2'd0;
    localparam logic [1:0] ROW_NONE_HI     = 2'd3;

    // Data pins shown during the two init waits.
    localparam logic [3:0] MID_WAIT_NIBBLE   = 4'h2;
    localparam logic [3:0] FINAL_WAIT_NIBBLE = 4'h1;

    typedef struct packed {
        in_item_t item;
        logic     no_phases;
    } lcd_request_row_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_item  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cfg_t      timing;
    out_item_t pending_phases[$];
    int        mismatch_count = 0;
    int        idle_pct       = 7;
    int        stall_pct      = 7;

    // Directed requests: extremes, every operation, ignored rows and codes.
    lcd_request_row_t directed_rows [19] = '{
        '{'{OP_CLEAR,        8'h00, 2'd0,        6'd0},  1'b0},
        '{'{OP_WRITE_CMD,    8'h00, 2'd0,        6'd0},  1'b0},
        '{'{OP_WRITE_CMD,    8'hFF, 2'd3,        6'd63}, 1'b0},
        '{'{OP_WRITE_DAT,    8'h00, 2'd0,        6'd0},  1'b0},
        '{'{OP_WRITE_DAT,    8'hFF, 2'd3,        6'd63}, 1'b0},
        '{'{OP_WRITE_DAT,    8'h5A, 2'd1,        6'd21}, 1'b0},
        '{'{OP_WRITE_CMD,    8'hA5, 2'd2,        6'd42}, 1'b0},
        '{'{OP_POSITION,     8'h00, ROW_LINE1,   6'd0},  1'b0},
        '{'{OP_POSITION,     8'hFF, ROW_LINE1,   6'd63}, 1'b0},
        '{'{OP_POSITION,     8'h00, ROW_LINE2,   6'd0},  1'b0},
        '{'{OP_POSITION,     8'hFF, ROW_LINE2,   6'd63}, 1'b0},
        '{'{OP_POSITION,     8'h12, ROW_NONE_LO, 6'd21}, 1'b1},
        '{'{OP_POSITION,     8'hFF, ROW_NONE_HI, 6'd63}, 1'b1},
        '{'{OP_RESERVED_LO,  8'h33, ROW_LINE1,   6'd5},  1'b1},
        '{'{OP_RESERVED_MID, 8'hFF, ROW_NONE_HI, 6'd63}, 1'b1},
        '{'{OP_RESERVED_HI,  8'h00, ROW_LINE2,   6'd0},  1'b1},
        '{'{OP_INIT,         8'hC3, ROW_NONE_HI, 6'd63}, 1'b0},
        '{'{OP_WRITE_DAT,    8'h41, ROW_LINE2,   6'd33}, 1'b0},
        '{'{OP_CLEAR,        8'hFF, ROW_NONE_HI, 6'd63}, 1'b0}
    };

    char_lcd_nibble_write_sequencer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Pin sequence model: appends one expected phase.
    function automatic void add_phase(logic rs, logic en, logic [3:0] nib,
                                      logic [HOLD_W-1:0] hold);
        out_item_t p;
        p.reg_select = rs;
        p.enable     = en;
        p.nibble     = nib;
        p.hold_us    = hold;
        p.last       = 1'b0;
        pending_phases.push_back(p);
    endfunction

    // One byte: settle, then high and low nibble, each placed and strobed.
    function automatic void add_byte(logic rs, logic [7:0] value);
        logic [3:0] nib;
        add_phase(rs, 1'b0, 4'h0, HOLD_W'(timing.rs_settle_us));
        for (int half = 0; half < 2; half++) begin
            nib = (half == 0) ? value[7:4] : value[3:0];
            add_phase(rs, 1'b0, nib, HOLD_W'(timing.nibble_setup_us));
            // Data bytes get a second setup hold before the strobe.
            if (rs)
                add_phase(rs, 1'b0, nib, HOLD_W'(timing.nibble_setup_us));
            add_phase(rs, 1'b1, nib, HOLD_W'(timing.strobe_width_us));
            add_phase(rs, 1'b0, nib, HOLD_W'(timing.strobe_width_us));
            add_phase(rs, 1'b0, nib, HOLD_W'(timing.nibble_setup_us));
        end
    endfunction

    // Returns the number of phases the request produces.
    function automatic int expand_request(in_item_t it);
        int        start;
        logic [7:0] addr;
        out_item_t tail;
        start = pending_phases.size();
        case (it.operation)
            OP_INIT: begin
                add_phase(1'b0, 1'b0, 4'h0, timing.power_up_wait_us);
                add_byte(1'b0, CMD_WAKE_A);
                add_byte(1'b0, CMD_WAKE_B);
                add_phase(1'b0, 1'b0, MID_WAIT_NIBBLE, timing.mid_init_wait_us);
                add_byte(1'b0, CMD_FUNCTION);
                add_byte(1'b0, CMD_DISPLAY_ON);
                add_byte(1'b0, CMD_ENTRY_MODE);
                add_byte(1'b0, CMD_CLEAR);
                add_phase(1'b0, 1'b0, FINAL_WAIT_NIBBLE, timing.final_init_wait_us);
            end
            OP_WRITE_CMD: add_byte(1'b0, it.byte_value);
            OP_WRITE_DAT: add_byte(1'b1, it.byte_value);
            OP_CLEAR:     add_byte(1'b0, CMD_CLEAR);
            OP_POSITION: begin
                // Line base plus column, wrapping at 8 bits.
                if (it.row == ROW_LINE1) begin
                    addr = LINE1_BASE + {2'b00, it.column};
                    add_byte(1'b0, addr);
                end else if (it.row == ROW_LINE2) begin
                    addr = LINE2_BASE + {2'b00, it.column};
                    add_byte(1'b0, addr);
                end
            end
            default: ;
        endcase
        if (pending_phases.size() > start) begin
            tail = pending_phases.pop_back();
            tail.last = 1'b1;
            pending_phases.push_back(tail);
        end
        return pending_phases.size() - start;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compares one output beat with the oldest expected phase.
    task automatic check_phase(out_item_t got);
        out_item_t want;
        if (pending_phases.size() == 0) begin
            report_mismatch($sformatf("unexpected phase %p", got));
        end else begin
            want = pending_phases.pop_front();
            if (got.reg_select !== want.reg_select)
                report_mismatch($sformatf("reg_select %b, expected %b",
                                          got.reg_select, want.reg_select));
            if (got.enable !== want.enable)
                report_mismatch($sformatf("enable %b, expected %b",
                                          got.enable, want.enable));
            if (got.nibble !== want.nibble)
                report_mismatch($sformatf("nibble %h, expected %h",
                                          got.nibble, want.nibble));
            if (got.hold_us !== want.hold_us)
                report_mismatch($sformatf("hold_us %0d, expected %0d",
                                          got.hold_us, want.hold_us));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, expected %b",
                                          got.last, want.last));
        end
    endtask

    // Output monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_phase(m_item);
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Drives one request beat and waits for its acceptance.
    task automatic send_request(in_item_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Register write: setup phase, access phase, then idle.
    task automatic apb_write(logic [2:0] index, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (index)
            REG_RS_SETTLE:    timing.rs_settle_us       = value[9:0];
            REG_NIBBLE_SETUP: timing.nibble_setup_us    = value[15:0];
            REG_STROBE_WIDTH: timing.strobe_width_us    = value[9:0];
            REG_POWER_WAIT:   timing.power_up_wait_us   = value[19:0];
            REG_MID_WAIT:     timing.mid_init_wait_us   = value[19:0];
            REG_FINAL_WAIT:   timing.final_init_wait_us = value[19:0];
            default: ;
        endcase
    endtask

    task automatic program_timing(cfg_t t);
        apb_write(REG_RS_SETTLE,    CFG_DATA_W'(t.rs_settle_us));
        apb_write(REG_NIBBLE_SETUP, CFG_DATA_W'(t.nibble_setup_us));
        apb_write(REG_STROBE_WIDTH, CFG_DATA_W'(t.strobe_width_us));
        apb_write(REG_POWER_WAIT,   CFG_DATA_W'(t.power_up_wait_us));
        apb_write(REG_MID_WAIT,     CFG_DATA_W'(t.mid_init_wait_us));
        apb_write(REG_FINAL_WAIT,   CFG_DATA_W'(t.final_init_wait_us));
    endtask

    // Waits until every expected phase has arrived, then lets the block settle.
    task automatic wait_idle();
        while (pending_phases.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random request, mostly real work, with some ignored rows and codes.
    function automatic in_item_t random_request();
        in_item_t it;
        int       pick;
        it.byte_value = 8'($urandom);
        it.column     = 6'($urandom);
        it.row        = 2'($urandom);
        pick = $urandom_range(99);
        if (pick < 8) begin
            it.operation = OP_INIT;
        end else if (pick < 32) begin
            it.operation = OP_WRITE_CMD;
        end else if (pick < 60) begin
            it.operation = OP_WRITE_DAT;
        end else if (pick < 68) begin
            it.operation = OP_CLEAR;
        end else if (pick < 95) begin
            it.operation = OP_POSITION;
            if ($urandom_range(9) != 0)
                it.row = $urandom_range(1) ? ROW_LINE2 : ROW_LINE1;
        end else begin
            it.operation = 3'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO));
        end
        return it;
    endfunction

    initial begin
        #(TIMEOUT_NS);
        $display("** char_lcd_nibble_write_sequencer: FAILED **");
        $finish;
    end

    initial begin
        cfg_t     t;
        in_item_t it;
        int       served;

        // Register defaults after reset.
        timing.rs_settle_us       = 10'd4;
        timing.nibble_setup_us    = 16'd830;
        timing.strobe_width_us    = 10'd83;
        timing.power_up_wait_us   = 20'd1000000;
        timing.mid_init_wait_us   = 20'd30000;
        timing.final_init_wait_us = 20'd10000;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the default timing.
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].item);
            if (!directed_rows[i].no_phases)
                void'(expand_request(directed_rows[i].item));
        end
        s_valid <= 1'b0;
        wait_idle();

        // Random part over several timing settings, extremes first.
        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            case (setting)
                0: t = '0;
                1: t = '1;
                default: begin
                    t.rs_settle_us       = 10'($urandom);
                    t.nibble_setup_us    = 16'($urandom);
                    t.strobe_width_us    = 10'($urandom);
                    t.power_up_wait_us   = 20'($urandom);
                    t.mid_init_wait_us   = 20'($urandom);
                    t.final_init_wait_us = 20'($urandom);
                end
            endcase
            program_timing(t);
            // Writes beyond the last register must leave the timing alone.
            if (setting == 2) begin
                apb_write(REG_UNUSED_LO, $urandom);
                apb_write(REG_UNUSED_HI, $urandom);
            end
            // One long stretch without any idling on either side.
            idle_pct  = (setting == 3) ? 0 : 7;
            stall_pct = (setting == 3) ? 0 : 7;
            served = 0;
            while (served < ITEMS_PER_SET) begin
                it = random_request();
                send_request(it);
                if (expand_request(it) > 0)
                    served++;
            end
            s_valid <= 1'b0;
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("** char_lcd_nibble_write_sequencer: PASSED **");
        else
            $display("** char_lcd_nibble_write_sequencer: FAILED **");
        $finish;
    end

endmodule
